// ===== design/elcd_pkg.sv =====
// Package for the escaped line command deframer.
// Character codes, register indexes, field widths and the structs that pass
// between the top level and the command matcher. No dependencies.
`default_nettype none

package elcd_pkg;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_PRINT_LO  = 8'h20;
   localparam logic [7:0] CH_PRINT_HI  = 8'h7E;

   localparam int CSR_INDEX_W = 3;
   localparam int CMD_WORD_W  = 64;
   localparam int CMD_LEN_W   = 4;
   localparam int CMD_COUNT_W = 3;
   localparam int LISTENER_W  = 3;
   localparam int PLEN_W      = 6;
   localparam int RSP_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_COMMAND_COUNT = 3'd6;

   typedef struct packed {
      logic [CMD_WORD_W-1:0] text;
      logic [CMD_LEN_W-1:0]  len;
      logic                  over;
   } cand_type;

   typedef struct packed {
      logic                  hit;
      logic [LISTENER_W-1:0] index;
   } match_type;

endpackage

`default_nettype wire

// ===== design/escaped_line_command_deframer.sv =====
// Escaped line command deframer, top level. Decodes one byte per word into
// payload words and end-of-line words. Uses elcd_pkg and elcd_match.
//
// Takes one received byte per cycle on req_ while req_tready is high and gives at
// most one result per byte on rsp_, in the cycle after the byte is taken; the line
// state and the result register update in that same cycle, and the command compare
// against all registered words runs in parallel at the newline. req_tready stays high
// unless a result is held in the output register and not taken. A backslash
// makes the next byte literal (escaped n gives a newline byte), the first
// unescaped colon splits command from payload, and an unescaped newline closes
// the line with an end word (rsp_tlast high) if anything was stored.
`default_nettype none

module escaped_line_command_deframer
   import elcd_pkg::*;
#(
   parameter int LINE_CAPACITY = 64,
   parameter int NUM_COMMANDS  = 6,
   parameter int COMMAND_CHARS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CMD_WORD_W-1:0]  csr_wdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] rx_byte
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,   // [7:0] data_byte, [8] matched,
                                                    // [11:9] listener_index,
                                                    // [17:12] payload_length, rest 0
   output logic                        rsp_tlast    // is_end
);

   localparam int CNT_W = $clog2(LINE_CAPACITY);
   localparam logic [CNT_W-1:0] STORE_MAX = CNT_W'(LINE_CAPACITY - 1);

   logic [NUM_COMMANDS-1:0][CMD_WORD_W-1:0] word_ff;
   logic [CMD_COUNT_W-1:0]                  count_ff;

   logic             esc_ff, esc_in;
   logic [CNT_W-1:0] stored_ff, stored_in;
   logic             sep_ff, sep_in;
   cand_type         filt_ff, filt_in;
   cand_type         cut_ff, cut_in;
   logic             cut_stop_ff, cut_stop_in;
   logic [PLEN_W-1:0] pcount_ff, pcount_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_end_ff, rsp_end_in;
   logic [7:0]            rsp_byte_ff, rsp_byte_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [LISTENER_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [PLEN_W-1:0]     rsp_len_ff, rsp_len_in;

   logic      accept;
   cand_type  cand;
   match_type match;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cand       = sep_ff ? filt_ff : cut_ff;

   elcd_match #(
      .NUM_COMMANDS  (NUM_COMMANDS),
      .COMMAND_CHARS (COMMAND_CHARS)
   ) u_match (
      .words  (word_ff),
      .count  (count_ff),
      .cand   (cand),
      .result (match)
   );

   always_comb begin
      logic [7:0] c;
      logic       literal;
      logic       do_store;
      logic       printable;
      logic       emit_pay;
      logic       emit_end;

      esc_in      = esc_ff;
      stored_in   = stored_ff;
      sep_in      = sep_ff;
      filt_in     = filt_ff;
      cut_in      = cut_ff;
      cut_stop_in = cut_stop_ff;
      pcount_in   = pcount_ff;
      emit_pay    = 1'b0;
      emit_end    = 1'b0;
      do_store    = 1'b0;
      literal     = 1'b0;
      c           = req_tdata;

      if (esc_ff) begin
         esc_in   = 1'b0;
         do_store = 1'b1;
         literal  = 1'b1;
         c        = (req_tdata == CH_LOWER_N) ? CH_NEWLINE : req_tdata;
      end else if (req_tdata == CH_BACKSLASH) begin
         esc_in = 1'b1;
      end else if (req_tdata == CH_NEWLINE) begin
         emit_end    = (stored_ff != '0);
         stored_in   = '0;
         sep_in      = 1'b0;
         filt_in     = '0;
         cut_in      = '0;
         cut_stop_in = 1'b0;
         pcount_in   = '0;
      end else begin
         do_store = 1'b1;
      end

      printable = (c >= CH_PRINT_LO) && (c <= CH_PRINT_HI);

      if (do_store && stored_ff < STORE_MAX) begin
         stored_in = stored_ff + 1'b1;
         if (sep_ff) begin
            emit_pay = 1'b1;
            if (pcount_ff != '1) begin
               pcount_in = pcount_ff + 1'b1;
            end
         end else if (!literal && c == CH_COLON) begin
            sep_in = 1'b1;
         end else begin
            if (printable) begin
               if (filt_ff.len < CMD_LEN_W'(COMMAND_CHARS)) begin
                  for (int i = 0; i < 8; i++) begin
                     if (filt_ff.len == CMD_LEN_W'(i)) begin
                        filt_in.text[8*i +: 8] = c;
                     end
                  end
                  filt_in.len = filt_ff.len + 1'b1;
               end else begin
                  filt_in.over = 1'b1;
               end
            end
            if (!cut_stop_ff) begin
               if (!printable) begin
                  cut_stop_in = 1'b1;
               end else if (cut_ff.len < CMD_LEN_W'(COMMAND_CHARS)) begin
                  for (int i = 0; i < 8; i++) begin
                     if (cut_ff.len == CMD_LEN_W'(i)) begin
                        cut_in.text[8*i +: 8] = c;
                     end
                  end
                  cut_in.len = cut_ff.len + 1'b1;
               end else begin
                  cut_in.over = 1'b1;
               end
            end
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_end_in   = rsp_end_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_len_in   = rsp_len_ff;
      if (accept && (emit_pay || emit_end)) begin
         rsp_valid_in = 1'b1;
         rsp_end_in   = emit_end;
         rsp_byte_in  = emit_end ? 8'h00 : c;
         rsp_hit_in   = emit_end && match.hit;
         rsp_idx_in   = emit_end ? match.index : '0;
         rsp_len_in   = emit_end ? pcount_ff : '0;
      end
   end

   for (genvar k = 0; k < NUM_COMMANDS; k++) begin : g_word
      always_ff @(posedge clock) begin
         if (reset) begin
            word_ff[k] <= '0;
         end else if (csr_we && csr_index == CSR_INDEX_W'(k)) begin
            word_ff[k] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_we && csr_index == REG_COMMAND_COUNT) begin
         count_ff <= csr_wdata[CMD_COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff       <= 1'b0;
         stored_ff    <= '0;
         sep_ff       <= 1'b0;
         filt_ff      <= '0;
         cut_ff       <= '0;
         cut_stop_ff  <= 1'b0;
         pcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            esc_ff      <= esc_in;
            stored_ff   <= stored_in;
            sep_ff      <= sep_in;
            filt_ff     <= filt_in;
            cut_ff      <= cut_in;
            cut_stop_ff <= cut_stop_in;
            pcount_ff   <= pcount_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_end_ff  <= rsp_end_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_len_ff  <= rsp_len_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_end_ff;
   assign rsp_tdata  = {6'b0, rsp_len_ff, rsp_idx_ff, rsp_hit_ff, rsp_byte_ff};

endmodule

`default_nettype wire

// ===== design/elcd_match.sv =====
// Command matcher: compares the candidate command of a line against the
// registered command words, lowest matching index wins. Uses elcd_pkg.
`default_nettype none

module elcd_match
   import elcd_pkg::*;
#(
   parameter int NUM_COMMANDS  = 6,
   parameter int COMMAND_CHARS = 8
) (
   input  wire logic [NUM_COMMANDS-1:0][CMD_WORD_W-1:0] words,
   input  wire logic [CMD_COUNT_W-1:0]                  count,
   input  wire cand_type                                cand,
   output match_type                                    result
);

   logic [NUM_COMMANDS-1:0] hit;

   always_comb begin
      logic [CMD_LEN_W-1:0] wlen;
      logic [7:0]           expect_byte;
      hit = '0;
      for (int k = 0; k < NUM_COMMANDS; k++) begin
         wlen = CMD_LEN_W'(COMMAND_CHARS);
         for (int i = COMMAND_CHARS - 1; i >= 0; i--) begin
            if (words[k][8*i +: 8] == 8'h00) begin
               wlen = CMD_LEN_W'(i);
            end
         end
         hit[k] = (wlen == cand.len) && !cand.over && (CMD_COUNT_W'(k) < count);
         for (int i = 0; i < 8; i++) begin
            expect_byte = (CMD_LEN_W'(i) < wlen) ? words[k][8*i +: 8] : 8'h00;
            if (expect_byte != cand.text[8*i +: 8]) begin
               hit[k] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      result = '0;
      for (int k = NUM_COMMANDS - 1; k >= 0; k--) begin
         if (hit[k]) begin
            result.hit   = 1'b1;
            result.index = LISTENER_W'(k);
         end
      end
   end

endmodule

`default_nettype wire

// ===== tb/escaped_line_command_deframer_tb.sv =====
// Testbench for escaped_line_command_deframer: drives raw line bytes and
// command tables, and checks each output word against an in-bench line decoder.
// Depends on elcd_pkg and the design files only.

module escaped_line_command_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import elcd_pkg::*;

   localparam int LINE_CAPACITY = 64;
   localparam int NUM_COMMANDS  = 6;
   localparam int COMMAND_CHARS = 8;
   localparam int QUIET_LIMIT   = 2000;

   localparam logic [CSR_INDEX_W-1:0] REG_COMMAND_WORD_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED         = 3'd7;

   typedef struct packed {
      logic                  is_end;
      logic [7:0]            data;
      logic                  matched;
      logic [LISTENER_W-1:0] listener;
      logic [PLEN_W-1:0]     plen;
   } decode_result_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CMD_WORD_W-1:0]  csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;

   escaped_line_command_deframer #(
      .LINE_CAPACITY(LINE_CAPACITY),
      .NUM_COMMANDS (NUM_COMMANDS),
      .COMMAND_CHARS(COMMAND_CHARS)
   ) dut (.*);

   // command table copy
   logic [CMD_WORD_W-1:0]  table_words [NUM_COMMANDS];
   logic [CMD_COUNT_W-1:0] table_count;
   logic [CMD_WORD_W-1:0]  next_words [NUM_COMMANDS];

   // line decoder state
   logic        esc_pending;
   int          stored;
   logic        sep_seen;
   logic [63:0] filt_text;
   int          filt_len;
   logic        filt_over;
   logic [63:0] cut_text;
   int          cut_len;
   logic        cut_stop;
   logic        cut_over;
   int          payload_cnt;

   decode_result_type pending_decodes[$];
   logic [7:0]        raw_line[$];

   int mismatches   = 0;
   int words_sent   = 0;
   int snd_idle_pct = 0;
   int rsp_idle_pct = 0;
   int rsp_hold     = 0;
   int quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- decoder
   function automatic void clear_line_state();
      esc_pending = 1'b0;
      stored      = 0;
      sep_seen    = 1'b0;
      filt_text   = '0;
      filt_len    = 0;
      filt_over   = 1'b0;
      cut_text    = '0;
      cut_len     = 0;
      cut_stop    = 1'b0;
      cut_over    = 1'b0;
      payload_cnt = 0;
   endfunction

   function automatic void add_command_char(input logic [7:0] c);
      logic is_print;
      is_print = (c >= CH_PRINT_LO) && (c <= CH_PRINT_HI);
      if (is_print) begin
         if (filt_len < COMMAND_CHARS) begin
            filt_text[8*filt_len +: 8] = c;
            filt_len++;
         end else begin
            filt_over = 1'b1;
         end
      end
      if (!cut_stop) begin
         if (!is_print) begin
            cut_stop = 1'b1;
         end else if (cut_len < COMMAND_CHARS) begin
            cut_text[8*cut_len +: 8] = c;
            cut_len++;
         end else begin
            cut_over = 1'b1;
         end
      end
   endfunction

   function automatic bit word_match(input logic [63:0] w, input logic [63:0] cand,
                                     input int clen);
      int          len;
      logic [63:0] mask;
      len = 0;
      while (len < COMMAND_CHARS && w[8*len +: 8] != 8'h00) len++;
      if (len != clen) return 1'b0;
      mask = (len >= 8) ? {64{1'b1}} : ((64'd1 << (8*len)) - 64'd1);
      return (w & mask) == cand;
   endfunction

   function automatic void store_decoded(input logic [7:0] c, input bit literal);
      decode_result_type r;
      if (stored >= LINE_CAPACITY - 1) return;
      stored++;
      if (sep_seen) begin
         r      = '0;
         r.data = c;
         pending_decodes.push_back(r);
         if (payload_cnt < 63) payload_cnt++;
      end else if (!literal && c == CH_COLON) begin
         sep_seen = 1'b1;
      end else begin
         add_command_char(c);
      end
   endfunction

   function automatic void close_line();
      logic [63:0]       cand;
      int                clen;
      logic              over;
      int                limit;
      decode_result_type r;
      if (stored > 0) begin
         cand   = sep_seen ? filt_text : cut_text;
         clen   = sep_seen ? filt_len : cut_len;
         over   = sep_seen ? filt_over : cut_over;
         limit  = (int'(table_count) > NUM_COMMANDS) ? NUM_COMMANDS : int'(table_count);
         r      = '0;
         r.is_end = 1'b1;
         r.plen   = payload_cnt[PLEN_W-1:0];
         if (!over) begin
            for (int k = 0; k < limit; k++) begin
               if (!r.matched && word_match(table_words[k], cand, clen)) begin
                  r.matched  = 1'b1;
                  r.listener = LISTENER_W'(k);
               end
            end
         end
         pending_decodes.push_back(r);
      end
      clear_line_state();
   endfunction

   function automatic void decode_rx_byte(input logic [7:0] c);
      if (esc_pending) begin
         esc_pending = 1'b0;
         store_decoded((c == CH_LOWER_N) ? CH_NEWLINE : c, 1'b1);
      end else if (c == CH_BACKSLASH) begin
         esc_pending = 1'b1;
      end else if (c == CH_NEWLINE) begin
         close_line();
      end else begin
         store_decoded(c, 1'b0);
      end
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic check_decoded();
      decode_result_type want;
      if (pending_decodes.size() == 0) begin
         report_mismatch("word with nothing pending", 64'(rsp_tdata), 64'(0));
      end else begin
         want = pending_decodes.pop_front();
         if (rsp_tlast !== want.is_end)
            report_mismatch("is_end", 64'(rsp_tlast), 64'(want.is_end));
         if (rsp_tdata[7:0] !== want.data)
            report_mismatch("data_byte", 64'(rsp_tdata[7:0]), 64'(want.data));
         if (rsp_tdata[8] !== want.matched)
            report_mismatch("matched", 64'(rsp_tdata[8]), 64'(want.matched));
         if (rsp_tdata[11:9] !== want.listener)
            report_mismatch("listener_index", 64'(rsp_tdata[11:9]), 64'(want.listener));
         if (rsp_tdata[17:12] !== want.plen)
            report_mismatch("payload_length", 64'(rsp_tdata[17:12]), 64'(want.plen));
         if (rsp_tdata[RSP_DATA_W-1:18] !== '0)
            report_mismatch("tdata padding", 64'(rsp_tdata[RSP_DATA_W-1:18]), 64'(0));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_decoded();
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** escaped_line_command_deframer: FAILED **");
         $finish;
      end
   end

   // receiver: random stalls, or a counted hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------- drivers
   task automatic send_word(input logic [7:0] b);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      decode_rx_byte(b);
      words_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i]);
   endtask

   task automatic send_line();
      foreach (raw_line[i]) send_word(raw_line[i]);
      raw_line.delete();
   endtask

   // sender pauses until every pending word has come out
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx < REG_COMMAND_COUNT)
         table_words[idx] = val;
      else if (idx == REG_COMMAND_COUNT)
         table_count = val[CMD_COUNT_W-1:0];
   endtask

   task automatic program_table(input logic [CMD_COUNT_W-1:0] count);
      settle();
      for (int k = 0; k < NUM_COMMANDS; k++)
         write_csr(REG_COMMAND_WORD_0 + CSR_INDEX_W'(k), next_words[k]);
      write_csr(REG_COMMAND_COUNT, 64'(count));
   endtask

   task automatic set_idle(input int snd_pct, input int rsp_pct);
      snd_idle_pct = snd_pct;
      rsp_idle_pct = rsp_pct;
   endtask

   // ---------------------------------------------------------------- builders
   function automatic logic [63:0] text_word(input string s);
      logic [63:0] w;
      w = '0;
      for (int i = 0; i < s.len() && i < COMMAND_CHARS; i++) w[8*i +: 8] = s[i];
      return w;
   endfunction

   function automatic logic [63:0] random_word();
      logic [63:0] w;
      int          n;
      w = '0;
      case ($urandom_range(0, 5))
         0: w = '0;
         1: w = {64{1'b1}};
         2: w = {$urandom, $urandom};
         default: begin
            n = $urandom_range(1, COMMAND_CHARS);
            for (int i = 0; i < n; i++)
               w[8*i +: 8] = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
         end
      endcase
      return w;
   endfunction

   function automatic void queue_char(input logic [7:0] c, input bit force_esc);
      if (c != CH_LOWER_N && (force_esc || c == CH_BACKSLASH || c == CH_NEWLINE ||
                              $urandom_range(0, 9) == 0)) begin
         raw_line.push_back(CH_BACKSLASH);
         raw_line.push_back((c == CH_NEWLINE && $urandom_range(0, 1)) ? CH_LOWER_N : c);
      end else begin
         raw_line.push_back(c);
      end
   endfunction

   // command (mostly a registered one), separator, payload, newline
   function automatic void queue_line();
      logic [7:0] cmd[$];
      int         pick;
      int         n;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         n = $urandom_range(0, NUM_COMMANDS - 1);
         for (int i = 0; i < COMMAND_CHARS && table_words[n][8*i +: 8] != 8'h00; i++)
            cmd.push_back(table_words[n][8*i +: 8]);
      end else begin
         n = $urandom_range(0, 10);
         repeat (n)
            cmd.push_back((pick < 8) ? 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI))
                                     : 8'($urandom_range(0, 255)));
      end
      foreach (cmd[i]) queue_char(cmd[i], cmd[i] == CH_COLON);
      if ($urandom_range(0, 9) < 8) raw_line.push_back(CH_COLON);
      n = ($urandom_range(0, 14) == 0) ? $urandom_range(30, 70) : $urandom_range(0, 8);
      repeat (n) queue_char(8'($urandom_range(0, 255)), 1'b0);
      if ($urandom_range(0, 19) != 0) raw_line.push_back(CH_NEWLINE);
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_escapes_and_framing();
      next_words = '{text_word("set"), text_word("get"), 64'h0, text_word("ABCDEFGH"),
                     text_word("get"), {64{1'b1}}};
      program_table(3'd6);
      write_csr(REG_UNUSED, {64{1'b1}});
      send_text("get:\\\n");
      send_word(8'h00);
      send_word(8'hFF);
      send_word(CH_NEWLINE);
      send_word(CH_NEWLINE);
      send_text(":\\n\\\\\\::\n");
      send_text("\\:x");
      send_word(8'h01);
      send_text("y\n");
   endtask

   task automatic test_command_table();
      logic [CMD_COUNT_W-1:0] count;
      for (int s = 0; s < 4; s++) begin
         foreach (next_words[k]) next_words[k] = random_word();
         case (s)
            0: count = 3'd0;
            1: begin
               count         = 3'd7;
               next_words[5] = text_word("ABCDEFGH");
            end
            2: begin
               count         = 3'd1;
               next_words[0] = '0;
            end
            default: count = CMD_COUNT_W'($urandom_range(1, NUM_COMMANDS));
         endcase
         program_table(count);
         repeat (3) begin
            queue_line();
            send_line();
         end
      end
   endtask

   task automatic test_line_overflow();
      settle();
      repeat (3) raw_line.push_back(8'($urandom_range(8'h61, 8'h7A)));
      raw_line.push_back(CH_COLON);
      repeat (70) queue_char(8'($urandom_range(0, 255)), 1'b0);
      raw_line.push_back(CH_NEWLINE);
      send_line();
      // command alone fills the line; the late colon is dropped
      repeat (70) raw_line.push_back(8'($urandom_range(8'h41, 8'h5A)));
      raw_line.push_back(CH_COLON);
      raw_line.push_back(8'h70);
      raw_line.push_back(CH_NEWLINE);
      send_line();
   endtask

   task automatic test_output_stall();
      settle();
      rsp_hold = 150;
      raw_line.push_back(CH_COLON);
      repeat (40) queue_char(8'($urandom_range(0, 255)), 1'b0);
      raw_line.push_back(CH_NEWLINE);
      send_line();
      settle();
   endtask

   task automatic test_random_stream(input int target);
      int start;
      start = words_sent;
      foreach (next_words[k]) next_words[k] = random_word();
      program_table(CMD_COUNT_W'($urandom_range(0, 7)));
      while (words_sent - start < target) begin
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(2, 10)) raw_line.push_back(8'($urandom_range(0, 255)));
         else
            queue_line();
         send_line();
      end
   endtask

   initial begin
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      foreach (table_words[k]) table_words[k] = '0;
      table_count = '0;
      clear_line_state();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_idle(8, 73);
      test_escapes_and_framing();
      test_command_table();
      test_line_overflow();
      set_idle(73, 8);
      test_output_stall();
      test_random_stream(65);
      set_idle(0, 0);
      test_random_stream(65);

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("** escaped_line_command_deframer: PASSED **");
      else
         $display("** escaped_line_command_deframer: FAILED **");
      $finish;
   end

endmodule
